[hw/rtl/swfd_pkg.sv]
// Shared constants and types for the sync word sensor frame deframer.
package swfd_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHAN_W  = 16;
  localparam int NUM_CHAN = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID   = 2'd2;

  // Register values after reset.
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h41;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h54;
  localparam logic [CHAN_W-1:0] MAX_VALID_RST   = 16'd4100;

  // Outcome of checking one completed frame.
  typedef struct packed {
    logic                             bad;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]  word;
  } frame_chk_t;

endpackage

[hw/rtl/sync_word_sensor_frame_deframer.sv]
// Top level of the sync word sensor frame deframer.
//
//   channel   direction  handshake              payload
//   rx        in         rx_valid / rx_stall    rx_byte
//   frame     out        frame_valid / frame_stall
//                                               channel_0..channel_3, rejected_count
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle unless stalled; the last payload byte of a frame is
// checked in the cycle it arrives and a passing frame is output in the next cycle.
// A single output register holds a result; rx_stall rises only when that register
// is full and stalled and the next byte would complete a frame.
// Reset (rst, synchronous) restores the sync pair, the limit and hunting mode,
// and clears the reject counter. cfg_ready is always high.
module sync_word_sensor_frame_deframer #(
  parameter int FRAME_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rx_valid,
  output logic                             rx_stall,
  input  logic [swfd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                             frame_valid,
  input  logic                             frame_stall,
  output logic [swfd_pkg::CHAN_W-1:0]      channel_0,
  output logic [swfd_pkg::CHAN_W-1:0]      channel_1,
  output logic [swfd_pkg::CHAN_W-1:0]      channel_2,
  output logic [swfd_pkg::CHAN_W-1:0]      channel_3,
  output logic [swfd_pkg::CHAN_W-1:0]      rejected_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [swfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swfd_pkg::CHAN_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    ST_HUNT    = 2'b01,
    ST_PAYLOAD = 2'b10
  } state_t;

  state_t                          state, state_next;
  logic [swfd_pkg::BYTE_W-1:0]     sync_first, sync_second;
  logic [swfd_pkg::CHAN_W-1:0]     max_valid;
  logic [swfd_pkg::BYTE_W-1:0]     previous_byte, previous_byte_next;
  logic [IDX_W-1:0]                payload_index, payload_index_next;
  logic [swfd_pkg::CHAN_W-1:0]     rejects, rejects_next;
  logic [swfd_pkg::BYTE_W-1:0]     payload_bytes [FRAME_BYTES-1];

  logic [FRAME_BYTES-1:0][swfd_pkg::BYTE_W-1:0] frame;
  swfd_pkg::frame_chk_t            chk;
  logic                            rx_take, last_byte, sync_hit, load_out;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= swfd_pkg::SYNC_FIRST_RST;
      sync_second <= swfd_pkg::SYNC_SECOND_RST;
      max_valid   <= swfd_pkg::MAX_VALID_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swfd_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data[swfd_pkg::BYTE_W-1:0];
        swfd_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data[swfd_pkg::BYTE_W-1:0];
        swfd_pkg::CFG_MAX_VALID:   max_valid   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request flow: hold off only when a completing byte would meet a full, stalled output.
  assign last_byte = (state == ST_PAYLOAD) && (payload_index == LAST_IDX);
  assign rx_stall  = frame_valid && frame_stall && last_byte;
  assign rx_take   = rx_valid && !rx_stall;
  assign sync_hit  = (previous_byte == sync_first) && (rx_byte == sync_second);

  // Assemble the full frame from the stored bytes and the arriving one.
  for (genvar j = 0; j < FRAME_BYTES - 1; j++) begin : g_frame
    assign frame[j] = payload_bytes[j];
  end
  assign frame[FRAME_BYTES-1] = rx_byte;

  swfd_check #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_check (
    .frame     (frame),
    .max_valid (max_valid),
    .chk       (chk)
  );

  assign load_out = rx_take && last_byte && !chk.bad;

  // Next state of the hunt and collect sequence.
  always_comb begin
    state_next         = state;
    previous_byte_next = previous_byte;
    payload_index_next = payload_index;
    rejects_next       = rejects;
    if (rx_take) begin
      case (state)
        ST_HUNT: begin
          if (sync_hit) begin
            state_next         = ST_PAYLOAD;
            payload_index_next = '0;
          end else begin
            previous_byte_next = rx_byte;
          end
        end
        ST_PAYLOAD: begin
          if (last_byte) begin
            state_next         = ST_HUNT;
            payload_index_next = '0;
            if (chk.bad && (rejects != '1)) begin
              rejects_next = rejects + 1'b1;
            end
          end else begin
            payload_index_next = payload_index + 1'b1;
          end
        end
        default: begin
          state_next = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_HUNT;
      previous_byte <= '0;
      payload_index <= '0;
      rejects       <= '0;
      frame_valid   <= 1'b0;
    end else begin
      state         <= state_next;
      previous_byte <= previous_byte_next;
      payload_index <= payload_index_next;
      rejects       <= rejects_next;
      frame_valid   <= load_out || (frame_valid && frame_stall);
    end
  end

  // Payload byte store, written at the current collect position.
  always_ff @(posedge clk) begin
    for (int j = 0; j < FRAME_BYTES - 1; j++) begin
      if (rx_take && (state == ST_PAYLOAD) && (payload_index == IDX_W'(j))) begin
        payload_bytes[j] <= rx_byte;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      channel_0      <= chk.word[0];
      channel_1      <= chk.word[1];
      channel_2      <= chk.word[2];
      channel_3      <= chk.word[3];
      rejected_count <= rejects;
    end
  end

  // A completed sync pair always starts collection at the first byte.
  a_sync_starts: assert property (@(posedge clk) disable iff (rst)
    rx_take && (state == ST_HUNT) && sync_hit |=>
      (state == ST_PAYLOAD) && (payload_index == '0))
    else $error("sync match did not start payload collection");

  // The last payload byte always returns the block to hunting.
  a_last_hunts: assert property (@(posedge clk) disable iff (rst)
    rx_take && last_byte |=> (state == ST_HUNT))
    else $error("frame end did not resume hunting");

  // A new result appears only after a completing byte was taken.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_valid) |-> $past(rx_take && last_byte))
    else $error("result appeared without a completed frame");

  // The reject counter stays at its ceiling.
  a_rej_sat: assert property (@(posedge clk) disable iff (rst)
    rejects == '1 |=> rejects == '1)
    else $error("reject counter wrapped");

endmodule

[hw/rtl/swfd_check.sv]
// Frame word packing and range check for a completed payload.
module swfd_check #(
  parameter int FRAME_BYTES = 8
) (
  input  logic [FRAME_BYTES-1:0][swfd_pkg::BYTE_W-1:0] frame,
  input  logic [swfd_pkg::CHAN_W-1:0]                  max_valid,
  output swfd_pkg::frame_chk_t                         chk
);

  localparam int NWORDS = FRAME_BYTES / 2;

  logic [NWORDS-1:0][swfd_pkg::CHAN_W-1:0] words;
  logic [NWORDS-1:0]                       over;

  // Pack byte pairs high byte first and compare each word with the limit.
  // A trailing odd byte takes no part.
  for (genvar w = 0; w < NWORDS; w++) begin : g_word
    assign words[w] = {frame[2*w], frame[2*w+1]};
    assign over[w]  = words[w] > max_valid;
  end

  assign chk.bad = |over;

  // Channels with no word behind them read as zero; extra words are checked only.
  for (genvar c = 0; c < swfd_pkg::NUM_CHAN; c++) begin : g_chan
    if (c < NWORDS) begin : g_used
      assign chk.word[c] = words[c];
    end else begin : g_empty
      assign chk.word[c] = '0;
    end
  end

endmodule
